// ----- design/qrs_pkg.sv -----
package qrs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   // headroom of the root field above the largest possible quotient
   localparam int ROOT_MARGIN    = 16;

   typedef enum logic [1:0] {
      STATUS_REAL     = 2'd0,
      STATUS_NEG_DISC = 2'd1,
      STATUS_A_ZERO   = 2'd2
   } status_type;

endpackage

// ----- design/qrs_if.sv -----
interface qrs_req_if #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] coef_a;
   logic signed [COEF_WIDTH-1:0] coef_b;
   logic signed [COEF_WIDTH-1:0] coef_c;

   modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
   modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_rsp_if #(
   parameter int DISC_WIDTH = 2 * qrs_pkg::COEF_WIDTH_DEF + 2,
   parameter int ROOT_WIDTH = qrs_pkg::COEF_WIDTH_DEF + qrs_pkg::FRAC_BITS_DEF
                              + qrs_pkg::ROOT_MARGIN
) ();
   import qrs_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [DISC_WIDTH-1:0] discriminant;
   logic signed [ROOT_WIDTH-1:0] root_plus;
   logic signed [ROOT_WIDTH-1:0] root_minus;
   status_type                   status;

   modport source (output valid, output discriminant, output root_plus, output root_minus,
                   output status, input ready);
   modport sink   (input valid, input discriminant, input root_plus, input root_minus,
                   input status, output ready);
endinterface

// ----- design/qrs_isqrt.sv -----
module qrs_isqrt #(
   parameter int RAD_W = 66,
   parameter int TAG_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [RAD_W-1:0]   in_rad,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output logic [RAD_W/2-1:0] out_root,
   output logic [TAG_W-1:0]   out_tag
);
   localparam int Q_W = RAD_W / 2;
   localparam int RMW = Q_W + 2;

   logic             valid_ff [Q_W];
   logic [RMW-1:0]   rem_ff   [Q_W];
   logic [Q_W-1:0]   root_ff  [Q_W];
   logic [RAD_W-1:0] rad_ff   [Q_W];
   logic [TAG_W-1:0] tag_ff   [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic             src_valid;
      logic [RMW-1:0]   src_rem;
      logic [Q_W-1:0]   src_root;
      logic [RAD_W-1:0] src_rad;
      logic [TAG_W-1:0] src_tag;
      logic [RMW-1:0]   rem_sh;
      logic [RMW-1:0]   trial;
      logic [RMW-1:0]   rem_in;
      logic [Q_W-1:0]   root_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = '0;
         assign src_root  = '0;
         assign src_rad   = in_rad;
         assign src_tag   = in_tag;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_root  = root_ff[k-1];
         assign src_rad   = rad_ff[k-1];
         assign src_tag   = tag_ff[k-1];
      end

      // one root bit per stage: bring down two radicand bits, try 4*root+1
      always_comb begin
         rem_sh = {src_rem[RMW-3:0], src_rad[RAD_W-1 -: 2]};
         trial  = {src_root, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {src_root[Q_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {src_root[Q_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {src_rad[RAD_W-3:0], 2'b00};
            tag_ff[k]  <= src_tag;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_root  = root_ff[Q_W-1];
   assign out_tag   = tag_ff[Q_W-1];
endmodule

// ----- design/qrs_div.sv -----
module qrs_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 17,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output logic [TAG_W-1:0] out_tag
);
   logic             valid_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff   [NUM_W];
   logic [NUM_W-1:0] num_ff   [NUM_W];
   logic [NUM_W-1:0] quot_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff   [NUM_W];
   logic [TAG_W-1:0] tag_ff   [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             src_valid;
      logic [DEN_W-1:0] src_rem;
      logic [NUM_W-1:0] src_num;
      logic [NUM_W-1:0] src_quot;
      logic [DEN_W-1:0] src_den;
      logic [TAG_W-1:0] src_tag;
      logic [DEN_W:0]   rem_sh;
      logic [DEN_W:0]   rem_sub;
      logic [DEN_W-1:0] rem_in;
      logic             q_bit;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = '0;
         assign src_num   = in_num;
         assign src_quot  = '0;
         assign src_den   = in_den;
         assign src_tag   = in_tag;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_num   = num_ff[k-1];
         assign src_quot  = quot_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_tag   = tag_ff[k-1];
      end

      // restoring step, one quotient bit per stage
      always_comb begin
         rem_sh  = {src_rem, src_num[NUM_W-1]};
         rem_sub = rem_sh - {1'b0, src_den};
         q_bit   = (rem_sh >= {1'b0, src_den});
         rem_in  = q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            num_ff[k]  <= {src_num[NUM_W-2:0], 1'b0};
            quot_ff[k] <= {src_quot[NUM_W-2:0], q_bit};
            den_ff[k]  <= src_den;
            tag_ff[k]  <= src_tag;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = quot_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];
endmodule

// ----- design/quadratic_root_solver.sv -----
// quadratic root solver: one equation a*x^2 + b*x + c = 0 per transaction
//
// req_ch carries the signed coefficients coef_a, coef_b, coef_c. rsp_ch returns the
// exact discriminant b*b - 4*a*c, the roots (-b +/- sqrt(d)) / (2a) in signed fixed
// point with FRAC_BITS fractional bits, and a status code (real roots, negative
// discriminant, zero a). On a nonzero status both roots read as zero.
//
// Throughput is one transaction per cycle unless the receiver stalls rsp_ch. The path from acceptance
// to rsp_ch.valid runs through two stages for the products and discriminant, one stage
// per square root bit, one stage to form the numerators, one stage per quotient bit in
// the two parallel dividers, and the output register.
//
// Synchronous reset clears every valid bit in the pipeline; data registers are not
// reset. When the receiver holds rsp_ch.ready low with a result waiting, the whole
// pipeline freezes and req_ch.ready drops; nothing is lost or repeated.
module quadratic_root_solver #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   qrs_req_if.sink   req_ch,
   qrs_rsp_if.source rsp_ch
);
   import qrs_pkg::*;

   localparam int CW     = COEF_WIDTH;
   localparam int DW     = 2 * CW + 2;
   localparam int RW     = CW + FRAC_BITS + ROOT_MARGIN;
   localparam int RAD_W  = DW + 2 * FRAC_BITS;
   localparam int SQ_W   = RAD_W / 2;
   localparam int NS_W   = SQ_W + 2;
   localparam int MAG_W  = SQ_W + 1;
   localparam int DEN_W  = CW + 1;
   localparam int STAG_W = DW + 2 + 2 * CW;
   localparam int PTAG_W = DW + 2 + 1;

   logic en;

   // stage a: products
   logic                   a_valid_ff;
   logic signed [CW-1:0]   a_a_ff, a_b_ff;
   logic signed [2*CW-1:0] a_bb_ff, a_ac_ff;

   // stage b: discriminant and status
   logic                   b_valid_ff;
   logic [DW-1:0]          b_d_ff;
   status_type             b_status_ff;
   logic [CW-1:0]          b_a_ff, b_b_ff;
   logic [DW-1:0]          d_in;
   status_type             status_in;

   // square root
   logic                   sq_valid;
   logic [SQ_W-1:0]        sq_root;
   logic [STAG_W-1:0]      sq_tag;
   logic [RAD_W-1:0]       rad_in;

   // stage c: numerators and divisor
   logic                   c_valid_ff;
   logic [MAG_W-1:0]       c_mag_p_ff, c_mag_m_ff;
   logic [DEN_W-1:0]       c_den_ff;
   logic                   c_neg_p_ff, c_neg_m_ff;
   logic [DW-1:0]          c_d_ff;
   status_type             c_status_ff;
   logic [DW-1:0]          t_d;
   logic [1:0]             t_status;
   logic [CW-1:0]          t_a, t_b;
   logic [NS_W-1:0]        b_ext, nb, np, nm, s_ext;
   logic [DEN_W-1:0]       den;

   // dividers
   logic                   dp_valid, dm_valid;
   logic [MAG_W-1:0]       dp_quot, dm_quot;
   logic [PTAG_W-1:0]      dp_tag;
   logic                   dm_tag;
   logic [DW-1:0]          o_d;
   logic [1:0]             o_status;
   logic                   o_neg_p;
   logic [RW-1:0]          qp_ext, qm_ext, rp_in, rm_in;

   // output register
   logic                   out_valid_ff;
   logic [DW-1:0]          out_d_ff;
   logic [RW-1:0]          out_rp_ff, out_rm_ff;
   status_type             out_status_ff;

   assign en           = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_ch.valid;
      end
      if (en) begin
         a_a_ff  <= req_ch.coef_a;
         a_b_ff  <= req_ch.coef_b;
         a_bb_ff <= req_ch.coef_b * req_ch.coef_b;
         a_ac_ff <= req_ch.coef_a * req_ch.coef_c;
      end
   end

   always_comb begin
      d_in = {{2{a_bb_ff[2*CW-1]}}, a_bb_ff} - {a_ac_ff, 2'b00};
      if (a_a_ff == '0) begin
         status_in = STATUS_A_ZERO;
      end else if (d_in[DW-1]) begin
         status_in = STATUS_NEG_DISC;
      end else begin
         status_in = STATUS_REAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         b_d_ff      <= d_in;
         b_status_ff <= status_in;
         b_a_ff      <= a_a_ff;
         b_b_ff      <= a_b_ff;
      end
   end

   // negative discriminant gives a don't-care root, feed zero
   assign rad_in = b_d_ff[DW-1] ? '0 : {b_d_ff, {(2 * FRAC_BITS){1'b0}}};

   qrs_isqrt #(
      .RAD_W (RAD_W),
      .TAG_W (STAG_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid_ff),
      .in_rad    (rad_in),
      .in_tag    ({b_d_ff, b_status_ff, b_a_ff, b_b_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   always_comb begin
      {t_d, t_status, t_a, t_b} = sq_tag;
      b_ext = {{(NS_W - CW){t_b[CW-1]}}, t_b};
      nb    = (~b_ext + 1'b1) << FRAC_BITS;
      s_ext = {2'b00, sq_root};
      np    = nb + s_ext;
      nm    = nb - s_ext;
      den   = {t_a, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= sq_valid;
      end
      if (en) begin
         c_mag_p_ff  <= np[NS_W-1] ? MAG_W'(~np + 1'b1) : np[MAG_W-1:0];
         c_mag_m_ff  <= nm[NS_W-1] ? MAG_W'(~nm + 1'b1) : nm[MAG_W-1:0];
         c_den_ff    <= den[DEN_W-1] ? (~den + 1'b1) : den;
         c_neg_p_ff  <= np[NS_W-1] ^ t_a[CW-1];
         c_neg_m_ff  <= nm[NS_W-1] ^ t_a[CW-1];
         c_d_ff      <= t_d;
         c_status_ff <= status_type'(t_status);
      end
   end

   qrs_div #(
      .NUM_W (MAG_W),
      .DEN_W (DEN_W),
      .TAG_W (PTAG_W)
   ) u_div_plus (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid_ff),
      .in_num    (c_mag_p_ff),
      .in_den    (c_den_ff),
      .in_tag    ({c_d_ff, c_status_ff, c_neg_p_ff}),
      .out_valid (dp_valid),
      .out_quot  (dp_quot),
      .out_tag   (dp_tag)
   );

   qrs_div #(
      .NUM_W (MAG_W),
      .DEN_W (DEN_W),
      .TAG_W (1)
   ) u_div_minus (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid_ff),
      .in_num    (c_mag_m_ff),
      .in_den    (c_den_ff),
      .in_tag    (c_neg_m_ff),
      .out_valid (dm_valid),
      .out_quot  (dm_quot),
      .out_tag   (dm_tag)
   );

   always_comb begin
      {o_d, o_status, o_neg_p} = dp_tag;
      qp_ext = {{(RW - MAG_W){1'b0}}, dp_quot};
      qm_ext = {{(RW - MAG_W){1'b0}}, dm_quot};
      if (o_status != STATUS_REAL) begin
         rp_in = '0;
         rm_in = '0;
      end else begin
         rp_in = o_neg_p ? (~qp_ext + 1'b1) : qp_ext;
         rm_in = dm_tag  ? (~qm_ext + 1'b1) : qm_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dp_valid;
      end
      if (en) begin
         out_d_ff      <= o_d;
         out_rp_ff     <= rp_in;
         out_rm_ff     <= rm_in;
         out_status_ff <= status_type'(o_status);
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.discriminant = out_d_ff;
   assign rsp_ch.root_plus    = out_rp_ff;
   assign rsp_ch.root_minus   = out_rm_ff;
   assign rsp_ch.status       = out_status_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      dp_valid == dm_valid)
      else $error("divider valids out of step");

   a_zero_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != STATUS_REAL |->
         rsp_ch.root_plus == '0 && rsp_ch.root_minus == '0)
      else $error("nonzero root with error status");

   a_zero_a_disc: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == STATUS_A_ZERO |-> !rsp_ch.discriminant[DW-1])
      else $error("negative discriminant with zero a");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> $stable(c_valid_ff) && $stable(b_valid_ff))
      else $error("pipeline moved during stall");
endmodule

// ----- tb/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qrs_pkg::*;

   localparam int CW = 16;
   localparam int FB = 16;
   localparam int DW = 34;
   localparam int RW = 48;
   localparam int LATENCY = 2 * CW + 2 * FB + 7;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic signed [DW-1:0] disc;
      logic signed [RW-1:0] rp;
      logic signed [RW-1:0] rm;
      status_type           st;
   } root_set_type;

   logic clock = 0;
   logic reset = 1;
   logic long_stalls = 0;
   int errors = 0;
   int idle_cycles = 0;
   int n_sent = 0, n_got = 0;
   int n_real = 0, n_neg = 0, n_azero = 0;
   root_set_type expected_roots[$];

   qrs_req_if #(.COEF_WIDTH(CW)) req_ch ();
   qrs_rsp_if rsp_ch ();

   quadratic_root_solver dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // floor(sqrt(v * 2^(2*FB))) by digit recurrence
   function automatic logic [63:0] frac_sqrt(logic [63:0] v);
      logic [127:0] x;
      logic [127:0] rem, root, trial;
      x = {64'b0, v} << (2 * FB);
      rem = 0;
      root = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 2) | ((x >> (2 * i)) & 128'd3);
         trial = (root << 2) | 128'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 128'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic root_set_type solve_roots(logic signed [CW-1:0] a,
                                                logic signed [CW-1:0] b,
                                                logic signed [CW-1:0] c);
      root_set_type r;
      longint d, s, nb, den;
      d = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
      r.disc = d[DW-1:0];
      r.rp = '0;
      r.rm = '0;
      if (a == 0) begin
         r.st = STATUS_A_ZERO;
      end else if (d < 0) begin
         r.st = STATUS_NEG_DISC;
      end else begin
         r.st = STATUS_REAL;
         s = longint'(frac_sqrt(d));
         nb = -longint'(b) * (longint'(1) << FB);
         den = 2 * longint'(a);
         r.rp = RW'((nb + s) / den);
         r.rm = RW'((nb - s) / den);
      end
      return r;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // valid stays high into the next transaction when there is no gap
   task automatic send_equation(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                logic signed [CW-1:0] c, bit gaps = 1);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_ch.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid  <= 1;
      req_ch.coef_a <= a;
      req_ch.coef_b <= b;
      req_ch.coef_c <= c;
      do @(posedge clock); while (!req_ch.ready);
      expected_roots.push_back(solve_roots(a, b, c));
      n_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 0;
      while (expected_roots.size() != 0) @(posedge clock);
   endtask

   task automatic test_extremes();
      logic signed [CW-1:0] ext[5] = '{16'sh8000, 16'sh7fff, 0, 1, -1};
      foreach (ext[i]) send_equation(ext[i], ext[(i + 1) % 5], ext[(i + 3) % 5]);
      send_equation(16'sh8000, 16'sh8000, 16'sh7fff, 0);  // largest discriminant
      send_equation(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);  // large negative discriminant
      send_equation(16'sh8000, 16'sh7fff, 16'sh8000, 0);
      send_equation(1, 0, 16'sh8000, 0);
      send_equation(-1, 16'sh8000, 0, 0);
      send_equation(16'sh5555, 16'shaaaa, 16'sh5555, 0);
   endtask

   task automatic test_special_cases();
      send_equation(0, 16'sh8000, 16'sh7fff);   // zero a, large b
      send_equation(0, 0, 0);                   // zero a, all zero
      send_equation(0, 5, -3);
      send_equation(1, 0, 1);                   // negative discriminant
      send_equation(16'sh7fff, 1, 16'sh7fff);
      send_equation(1, 2, 1);                   // double root
      send_equation(1, -3, 2);                  // two integer roots
      send_equation(-2, 1, 3);
      send_equation(3, 7, -5);                  // irrational roots
      send_equation(1, 1, 0);
   endtask

   task automatic test_random(int count);
      logic signed [CW-1:0] a, b, c;
      int mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         a = CW'($urandom);
         b = CW'($urandom);
         c = CW'($urandom);
         if (mode < 2) begin
            a = CW'($urandom_range(0, 15) - 8);
            b = CW'($urandom_range(0, 63) - 32);
            c = CW'($urandom_range(0, 63) - 32);
         end else if (mode == 2) begin
            a = 0;
         end else if (mode == 3) begin
            // b = -a*(p+q) and c = a*p*q shape, with p and q drawn separately for b and c
            a = CW'($urandom_range(1, 8));
            b = CW'(-a * (($urandom_range(0, 40) - 20) + ($urandom_range(0, 40) - 20)));
            c = CW'(a * ($urandom_range(0, 10) - 5) * ($urandom_range(0, 10) - 5));
         end
         send_equation(a, b, c);
         if (i == count / 2) begin
            wait_drained();
            repeat ($urandom_range(5, 20)) @(posedge clock);
         end
      end
   endtask

   task automatic test_back_pressure();
      long_stalls = 1;
      for (int i = 0; i < 60; i++) begin
         send_equation(CW'($urandom), CW'($urandom), CW'($urandom), 0);
      end
      wait_drained();
      long_stalls = 0;
   endtask

   // receiver ready with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (long_stalls) begin
         rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      end else if ($urandom_range(0, 49) == 0) begin
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      root_set_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_got++;
         if (expected_roots.size() == 0) begin
            $error("unexpected transaction: disc %0d", rsp_ch.discriminant);
            errors++;
         end else begin
            exp_r = expected_roots.pop_front();
            case (exp_r.st)
               STATUS_REAL:     n_real++;
               STATUS_NEG_DISC: n_neg++;
               default:         n_azero++;
            endcase
            if (rsp_ch.discriminant !== exp_r.disc) begin
               $error("discriminant: expected %0d actual %0d", exp_r.disc, rsp_ch.discriminant);
               errors++;
            end
            if (rsp_ch.root_plus !== exp_r.rp) begin
               $error("root_plus: expected %0d actual %0d", exp_r.rp, rsp_ch.root_plus);
               errors++;
            end
            if (rsp_ch.root_minus !== exp_r.rm) begin
               $error("root_minus: expected %0d actual %0d", exp_r.rm, rsp_ch.root_minus);
               errors++;
            end
            if (rsp_ch.status !== exp_r.st) begin
               $error("status: expected %s actual %s", exp_r.st.name(), rsp_ch.status.name());
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid  = 0;
      req_ch.coef_a = '0;
      req_ch.coef_b = '0;
      req_ch.coef_c = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      test_extremes();
      test_special_cases();
      test_back_pressure();
      test_random(900);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d equations, checked %0d results", n_sent, n_got);
      $display("real %0d, negative discriminant %0d, zero a %0d", n_real, n_neg, n_azero);
      if (errors == 0 && expected_roots.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
